/* sv/snp_pkg.sv */
// Package for the spiking neural P system step engine.
// Holds sizes, opcodes and the packed transaction types; no dependencies.
package snp_pkg;
  localparam int MaxNeurons = 16;
  localparam int MaxRules = 32;
  localparam int CountWidth = 16;
  localparam int NW = $clog2(MaxNeurons);
  localparam int RW = $clog2(MaxRules);

  typedef enum logic [2:0] {
    OP_SET_SPIKES = 3'd0,
    OP_LOAD_RULE  = 3'd1,
    OP_SET_SYN    = 3'd2,
    OP_STEP       = 3'd3,
    OP_READ       = 3'd4
  } opcode_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         neuron_index;
    logic [4:0]         rule_index;
    logic [3:0]         target_neuron;
    logic signed [15:0] spike_value;
    logic [7:0]         consumed_spikes;
    logic [7:0]         produced_spikes;
    logic [7:0]         rule_delay;
    logic signed [15:0] spike_threshold;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] spike_count;
    logic [5:0]         rules_fired;
  } out_item_t;
endpackage

/* sv/spiking_p_system_step_engine.sv */
// Top level of the spiking neural P system step engine.
// Depends on snp_pkg for sizes, opcodes and transaction types.
//
//   channel   signals                          direction
//   command   in_valid, in_ready, in_data      into the block
//   result    out_valid, out_ready, out_data   out of the block
//   config    cfg_we, cfg_data                 into the block, no wait
//
// Every command except step goes from the execute state straight to the output state.
// A step walks the rule slots in a sequence of passes: a close pass,
// a select pass per neuron (up to 32 slots each), a fire pass, a gain pass
// that walks the targets of each fired rule, a neuron update pass and a
// countdown pass with a 32-slot sibling walk per selected delayed rule.
// Reset is synchronous and clears the spike counts, synapses, rule valid
// and waiting flags and countdowns. A result waits in the output register
// while out_ready is low, and no new command is taken until it goes.
module spiking_p_system_step_engine
  import snp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [4:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_CLOSE, S_SEL, S_FIRE, S_GAIN, S_UPD, S_CNT, S_SIB, S_OUT
  } state_t;

  state_t state;
  in_item_t cmd;
  logic [4:0] niu;
  // Spike counts, synapses and per-rule control live in flip-flops.
  logic signed [CountWidth-1:0] spikes [MaxNeurons];
  logic [MaxNeurons-1:0] syn [MaxNeurons];
  logic [MaxRules-1:0] rvalid, waitf, sel, fire;
  logic [7:0] dcnt [MaxRules];
  logic [MaxNeurons-1:0] closed;
  logic signed [CountWidth+9:0] gain [MaxNeurons];
  // Rule fields are undefined until loaded.
  logic [NW-1:0] rown [MaxRules];
  logic [7:0] rcons [MaxRules], rprod [MaxRules], rwait [MaxRules];
  logic signed [15:0] rmin [MaxRules];

  logic [RW-1:0] ri;   // rule walk index
  logic [NW:0] ni;     // neuron walk index
  logic [RW-1:0] ti;   // sibling walk index
  logic [5:0] fired;
  logic [4:0] nu;

  assign nu = (niu > 5'(MaxNeurons)) ? 5'(MaxNeurons) : niu;
  assign in_ready = (state == S_IDLE);

  logic [RW-1:0] r;
  logic [NW-1:0] n;
  logic signed [CountWidth+10:0] sum;
  logic signed [CountWidth-1:0] satv;
  assign r = ri;
  assign n = ni[NW-1:0];
  // Shared adder and saturation for the update pass.
  assign sum = (CountWidth+11)'(spikes[n]) + (CountWidth+11)'(gain[n]);
  always_comb begin
    if (sum > (CountWidth+11)'(32767)) satv = 16'sd32767;
    else if (sum < -(CountWidth+11)'(32768)) satv = -16'sd32768;
    else satv = sum[CountWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      niu <= 5'd16;
      rvalid <= '0;
      waitf <= '0;
      for (int i = 0; i < MaxNeurons; i++) begin
        spikes[i] <= '0;
        syn[i] <= '0;
      end
      for (int i = 0; i < MaxRules; i++) dcnt[i] <= '0;
    end else begin
      if (cfg_we) niu <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= in_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          fired <= '0;
          if (cmd.opcode == OP_READ && 5'(cmd.neuron_index) < nu)
            out_data.spike_count <= spikes[cmd.neuron_index];
          else
            out_data.spike_count <= '0;
          unique case (cmd.opcode)
            OP_SET_SPIKES: begin
              if (5'(cmd.neuron_index) < nu) spikes[cmd.neuron_index] <= cmd.spike_value;
              state <= S_OUT;
            end
            OP_LOAD_RULE: begin
              rvalid[cmd.rule_index] <= 1'b1;
              rown[cmd.rule_index] <= cmd.neuron_index;
              rcons[cmd.rule_index] <= cmd.consumed_spikes;
              rprod[cmd.rule_index] <= cmd.produced_spikes;
              rwait[cmd.rule_index] <= cmd.rule_delay;
              rmin[cmd.rule_index] <= cmd.spike_threshold;
              state <= S_OUT;
            end
            OP_SET_SYN: begin
              syn[cmd.neuron_index][cmd.target_neuron] <= 1'b1;
              state <= S_OUT;
            end
            OP_STEP: begin
              closed <= '0;
              sel <= '0;
              fire <= '0;
              for (int i = 0; i < MaxNeurons; i++) gain[i] <= '0;
              ri <= '0;
              ni <= '0;
              state <= S_CLOSE;
            end
            OP_READ: begin
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_CLOSE: begin
          if (rvalid[r] && 5'(rown[r]) < nu && dcnt[r] != 8'd0) closed[rown[r]] <= 1'b1;
          if (r == RW'(MaxRules-1)) begin
            ri <= '0;
            state <= S_SEL;
          end else begin
            ri <= ri + 1'b1;
          end
        end
        S_SEL: begin
          // Neuron n scans slots until its first matching rule.
          if (5'(ni) >= nu) begin
            ri <= '0;
            state <= S_FIRE;
          end else if (closed[n]) begin
            ni <= ni + 1'b1;
          end else if (rvalid[r] && rown[r] == n && spikes[n] >= rmin[r]) begin
            sel[r] <= 1'b1;
            ri <= '0;
            ni <= ni + 1'b1;
          end else if (r == RW'(MaxRules-1)) begin
            ri <= '0;
            ni <= ni + 1'b1;
          end else begin
            ri <= ri + 1'b1;
          end
        end
        S_FIRE: begin
          if (rvalid[r]) begin
            logic f;
            f = (sel[r] || waitf[r]) && dcnt[r] == 8'd0;
            fire[r] <= f;
            waitf[r] <= (waitf[r] && !f) || (sel[r] && rwait[r] != 8'd0);
            if (f) fired <= fired + 1'b1;
          end
          if (r == RW'(MaxRules-1)) begin
            ri <= '0;
            ni <= '0;
            state <= S_GAIN;
          end else begin
            ri <= ri + 1'b1;
          end
        end
        S_GAIN: begin
          // For a fired rule, ni walks targets; target index MaxNeurons
          // stands for the owner's consumption.
          if (!fire[r] || 5'(rown[r]) >= nu) begin
            ni <= '0;
            ri <= ri + 1'b1;
            if (r == RW'(MaxRules-1)) state <= S_UPD;
          end else if (ni == (NW+1)'(MaxNeurons)) begin
            gain[rown[r]] <= gain[rown[r]] - (CountWidth+10)'(rcons[r]);
            ni <= '0;
            ri <= ri + 1'b1;
            if (r == RW'(MaxRules-1)) state <= S_UPD;
          end else begin
            if (5'(ni) < nu && syn[rown[r]][n])
              gain[n] <= gain[n] + (CountWidth+10)'(rprod[r]);
            ni <= ni + 1'b1;
          end
        end
        S_UPD: begin
          if (5'(ni) >= nu) begin
            ri <= '0;
            state <= S_CNT;
          end else begin
            if (!closed[n]) spikes[n] <= satv;
            ni <= ni + 1'b1;
          end
        end
        S_CNT: begin
          if (rvalid[r]) begin
            if (dcnt[r] != 8'd0) dcnt[r] <= dcnt[r] - 1'b1;
            if (sel[r] && rwait[r] != 8'd0) begin
              ti <= '0;
              state <= S_SIB;
            end
          end
          if (!(rvalid[r] && sel[r] && rwait[r] != 8'd0)) begin
            ri <= ri + 1'b1;
            if (r == RW'(MaxRules-1)) state <= S_OUT;
          end
        end
        S_SIB: begin
          // Later siblings are decremented once when the pass reaches them.
          if (rvalid[ti] && rown[ti] == rown[r])
            dcnt[ti] <= rwait[r];
          ti <= ti + 1'b1;
          if (ti == RW'(MaxRules-1)) begin
            ri <= ri + 1'b1;
            state <= (r == RW'(MaxRules-1)) ? S_OUT : S_CNT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_data.rules_fired <= fired;
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/snp_checker.sv */
// Port-level checker for the step engine, bound to the top level.
// Depends on snp_pkg for transaction types.
module snp_checker
  import snp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_fired_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.rules_fired <= 6'd32) else $error("too many fired");
endmodule

bind spiking_p_system_step_engine snp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* tb/testbench.sv */
// Self-checking testbench for the spiking neural P system step engine.
// Depends on snp_pkg and spiking_p_system_step_engine; predicts every result
// from a behavioral copy of the system state and checks it field by field.
module testbench;
  import snp_pkg::*;

  // Opcodes 5 to 7 are not defined; the block must ignore them and answer zero.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam int IdleLimit = 20000;
  localparam int CountMax = 32767;
  localparam int CountMin = -32768;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [4:0] cfg_data;

  spiking_p_system_step_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Predicted system state. The rule field arrays are only ever read for
  // slots that have been loaded, matching the block's own behavior.
  logic [4:0]         sys_neurons;
  logic signed [15:0] sys_spikes[MaxNeurons];
  logic               sys_rule_valid[MaxRules];
  logic [3:0]         sys_rule_owner[MaxRules];
  logic [7:0]         sys_rule_consume[MaxRules];
  logic [7:0]         sys_rule_produce[MaxRules];
  logic [7:0]         sys_rule_delay[MaxRules];
  logic signed [15:0] sys_rule_threshold[MaxRules];
  logic [15:0]        sys_synapses[MaxNeurons];
  logic [7:0]         sys_countdown[MaxRules];
  logic               sys_waiting[MaxRules];

  out_item_t pending_results[$];
  int        error_count = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  bit        gaps_on = 1'b1;
  int        stall_mode = 0;
  int        stall_tick = 0;

  // Values above the array size behave like the full array.
  function automatic int neurons_active();
    return (sys_neurons > MaxNeurons) ? MaxNeurons : int'(sys_neurons);
  endfunction

  function automatic logic signed [15:0] saturate_count(longint v);
    if (v > CountMax) return 16'(CountMax);
    if (v < CountMin) return 16'(CountMin);
    return 16'(v);
  endfunction

  // Advances the system by one step and returns the number of rules fired.
  // The order of the passes matters: closing uses the old countdowns, and the
  // countdown walk sets sibling counters before later slots are decremented.
  function automatic int advance_system();
    bit     closed[MaxNeurons];
    bit     selected[MaxRules];
    bit     fires[MaxRules];
    longint gain[MaxNeurons];
    int     nu;
    int     fired;
    int     o;
    bit     keep;
    nu = neurons_active();
    fired = 0;
    for (int n = 0; n < MaxNeurons; n++) begin
      closed[n] = 1'b0;
      gain[n] = 0;
    end
    for (int r = 0; r < MaxRules; r++) begin
      selected[r] = 1'b0;
      fires[r] = 1'b0;
    end
    for (int r = 0; r < MaxRules; r++) begin
      if (sys_rule_valid[r] && sys_rule_owner[r] < nu && sys_countdown[r] > 0) begin
        closed[sys_rule_owner[r]] = 1'b1;
      end
    end
    // Each open neuron takes its lowest-numbered rule whose threshold it meets.
    for (int n = 0; n < nu; n++) begin
      if (!closed[n]) begin
        for (int r = 0; r < MaxRules; r++) begin
          if (sys_rule_valid[r] && sys_rule_owner[r] == n &&
              int'(sys_spikes[n]) >= int'(sys_rule_threshold[r])) begin
            selected[r] = 1'b1;
            break;
          end
        end
      end
    end
    for (int r = 0; r < MaxRules; r++) begin
      if (sys_rule_valid[r]) begin
        fires[r] = (selected[r] || sys_waiting[r]) && sys_countdown[r] == 0;
        keep = sys_waiting[r] && !fires[r];
        sys_waiting[r] = keep || (selected[r] && sys_rule_delay[r] > 0);
        if (fires[r]) fired++;
      end
    end
    for (int r = 0; r < MaxRules; r++) begin
      if (fires[r]) begin
        o = sys_rule_owner[r];
        if (o < nu) begin
          gain[o] -= sys_rule_consume[r];
          if (sys_rule_produce[r] > 0) begin
            for (int t = 0; t < nu; t++) begin
              if (sys_synapses[o][t]) gain[t] += sys_rule_produce[r];
            end
          end
        end
      end
    end
    for (int n = 0; n < nu; n++) begin
      if (!closed[n]) sys_spikes[n] = saturate_count(longint'(sys_spikes[n]) + gain[n]);
    end
    for (int r = 0; r < MaxRules; r++) begin
      if (sys_rule_valid[r]) begin
        if (sys_countdown[r] > 0) sys_countdown[r]--;
        if (selected[r] && sys_rule_delay[r] > 0) begin
          for (int t = 0; t < MaxRules; t++) begin
            if (sys_rule_valid[t] && sys_rule_owner[t] == sys_rule_owner[r]) begin
              sys_countdown[t] = sys_rule_delay[r];
            end
          end
        end
      end
    end
    return fired;
  endfunction

  // Applies one command to the predicted state and returns its answer.
  function automatic out_item_t apply_command(in_item_t c);
    out_item_t res;
    res = '0;
    case (c.opcode)
      OP_SET_SPIKES: begin
        if (c.neuron_index < neurons_active()) sys_spikes[c.neuron_index] = c.spike_value;
      end
      OP_LOAD_RULE: begin
        // Reloading keeps the slot's countdown and waiting flag.
        sys_rule_valid[c.rule_index]     = 1'b1;
        sys_rule_owner[c.rule_index]     = c.neuron_index;
        sys_rule_consume[c.rule_index]   = c.consumed_spikes;
        sys_rule_produce[c.rule_index]   = c.produced_spikes;
        sys_rule_delay[c.rule_index]     = c.rule_delay;
        sys_rule_threshold[c.rule_index] = c.spike_threshold;
      end
      OP_SET_SYN: sys_synapses[c.neuron_index][c.target_neuron] = 1'b1;
      OP_STEP:    res.rules_fired = 6'(advance_system());
      OP_READ: begin
        if (c.neuron_index < neurons_active()) res.spike_count = sys_spikes[c.neuron_index];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Prediction happens at the edge where a command transaction is accepted.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      pending_results.insert(pending_results.size(), apply_command(in_data));
  end

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result spike_count=%0d rules_fired=%0d",
                 $time, out_data.spike_count, out_data.rules_fired);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.spike_count !== want.spike_count) begin
          $display("%0t: spike_count expected %0d actual %0d",
                   $time, want.spike_count, out_data.spike_count);
          error_count++;
        end
        if (out_data.rules_fired !== want.rules_fired) begin
          $display("%0t: rules_fired expected %0d actual %0d",
                   $time, want.rules_fired, out_data.rules_fired);
          error_count++;
        end
      end
    end
  end

  // The receiver switches at random between four stall behaviors: always
  // ready, coin flips, mostly ready, or mostly stalled.
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Watchdog: a long stretch with no transaction on either channel means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sends one command. The sender works in bursts; between bursts it may
  // drop valid for a random gap. Within a burst valid stays high.
  task automatic send_command(input in_item_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits on the clock first so that the prediction for the last accepted command is
  // already queued before the queue is checked.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // The register is only written with nothing in flight.
  task automatic write_neuron_count(input logic [4:0] value);
    wait_all_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    sys_neurons = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t make_command(logic [2:0] op, int ni, int ri, int tn, int sv,
                                            int cons, int prod, int dly, int thr);
    in_item_t c;
    c.opcode          = op;
    c.neuron_index    = 4'(ni);
    c.rule_index      = 5'(ri);
    c.target_neuron   = 4'(tn);
    c.spike_value     = 16'(sv);
    c.consumed_spikes = 8'(cons);
    c.produced_spikes = 8'(prod);
    c.rule_delay      = 8'(dly);
    c.spike_threshold = 16'(thr);
    return c;
  endfunction

  function automatic in_item_t random_fields();
    in_item_t c;
    c = in_item_t'(72'({$urandom, $urandom, $urandom}));
    return c;
  endfunction

  // Mostly neurons in use, now and then any index to hit the ignore paths.
  function automatic logic [3:0] pick_neuron();
    int nu;
    nu = neurons_active();
    if (nu == 0 || $urandom_range(0, 9) == 0) return 4'($urandom);
    return 4'($urandom_range(0, nu - 1));
  endfunction

  // Extremes of counts and thresholds, duplicate and self synapses, delays,
  // a slot reload, saturation both ways, unknown opcodes, and neurons out of
  // range once the count in use is lowered.
  task automatic test_directed();
    send_command(make_command(OP_LOAD_RULE, 0, 0, 0, 0, 255, 255, 0, CountMin));
    send_command(make_command(OP_LOAD_RULE, 0, 1, 0, 0, 1, 1, 2, CountMax));
    send_command(make_command(OP_LOAD_RULE, 15, 31, 0, 0, 0, 0, 255, CountMax));
    send_command(make_command(OP_LOAD_RULE, 1, 5, 0, 0, 3, 7, 1, 0));
    send_command(make_command(OP_SET_SYN, 0, 0, 15, 0, 0, 0, 0, 0));
    send_command(make_command(OP_SET_SYN, 0, 0, 15, 0, 0, 0, 0, 0));
    send_command(make_command(OP_SET_SYN, 1, 0, 1, 0, 0, 0, 0, 0));
    send_command(make_command(OP_SET_SPIKES, 15, 0, 0, CountMax, 0, 0, 0, 0));
    send_command(make_command(OP_SET_SPIKES, 0, 0, 0, CountMin, 0, 0, 0, 0));
    send_command(make_command(OP_SET_SPIKES, 1, 0, 0, 5, 0, 0, 0, 0));
    send_command(make_command(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_READ, 15, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_LOAD_RULE, 1, 5, 0, 0, 2, 9, 0, CountMin));
    send_command(make_command(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_UNUSED_FIRST, 15, 31, 15, -1, 255, 255, 255, -1));
    send_command(make_command(OP_UNUSED_LAST, 15, 31, 15, -1, 255, 255, 255, -1));
    write_neuron_count(5'd3);
    send_command(make_command(OP_SET_SPIKES, 15, 0, 0, 77, 0, 0, 0, 0));
    send_command(make_command(OP_READ, 15, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_READ, 2, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Random programs: load a few rules, wire synapses, seed counts, then run
  // several steps with reads in between. About one round in ten is a single
  // noise command with every field random, unknown opcodes included.
  task automatic test_random_programs(input int total);
    in_item_t c;
    int sent;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(0, 9) == 0) begin
        c = random_fields();
        send_command(c);
        sent++;
      end else begin
        repeat ($urandom_range(1, 5)) begin
          c = random_fields();
          c.opcode = OP_LOAD_RULE;
          c.neuron_index = pick_neuron();
          if ($urandom_range(0, 9) != 0) begin
            c.spike_threshold = 16'(int'($urandom_range(0, 15)) - 3);
            c.rule_delay = 8'($urandom_range(0, 3));
            c.consumed_spikes = 8'($urandom_range(0, 4));
            c.produced_spikes = 8'($urandom_range(0, 4));
          end
          send_command(c);
          sent++;
        end
        repeat ($urandom_range(1, 4)) begin
          c = random_fields();
          c.opcode = OP_SET_SYN;
          c.neuron_index = pick_neuron();
          c.target_neuron = pick_neuron();
          send_command(c);
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          c = random_fields();
          c.opcode = OP_SET_SPIKES;
          c.neuron_index = pick_neuron();
          if ($urandom_range(0, 9) != 0) c.spike_value = 16'($urandom_range(0, 15));
          send_command(c);
          sent++;
        end
        repeat ($urandom_range(2, 8)) begin
          c = random_fields();
          c.opcode = OP_STEP;
          send_command(c);
          sent++;
          if ($urandom_range(0, 1) == 1) begin
            c = random_fields();
            c.opcode = OP_READ;
            c.neuron_index = pick_neuron();
            send_command(c);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    sys_neurons = 5'd16;
    for (int n = 0; n < MaxNeurons; n++) begin
      sys_spikes[n] = '0;
      sys_synapses[n] = '0;
    end
    for (int r = 0; r < MaxRules; r++) begin
      sys_rule_valid[r] = 1'b0;
      sys_countdown[r] = '0;
      sys_waiting[r] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_neuron_count(5'd16);
    test_directed();
    write_neuron_count(5'd1);
    gaps_on = 1'b0;
    test_random_programs(150);
    write_neuron_count(5'd31);
    gaps_on = 1'b1;
    test_random_programs(200);
    write_neuron_count(5'd0);
    test_random_programs(50);
    write_neuron_count(5'd5);
    gaps_on = 1'b0;
    test_random_programs(250);
    write_neuron_count(5'd16);
    gaps_on = 1'b1;
    test_random_programs(350);

    wait_all_results();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* spiking_p_system_step_engine.f */
sv/snp_pkg.sv
sv/spiking_p_system_step_engine.sv
sv/snp_checker.sv
tb/testbench.sv
